/* rtl/rfp_pkg.sv */
package rfp_pkg;

    localparam int FRAME_ROWS         = 7;
    localparam int SCORE_BITS_DEFAULT = 32;
    localparam int DATA_BITS          = 32;
    localparam int ROW_BITS           = 3;
    localparam int PHASE_BITS         = 2;

    localparam logic [ROW_BITS-1:0]   ROW_FIRST     = 3'd0;
    localparam logic [ROW_BITS-1:0]   ROW_REV_BASE  = 3'd3;
    localparam logic [ROW_BITS-1:0]   ROW_NONCODING = 3'd6;
    localparam logic [PHASE_BITS-1:0] PHASE_FIRST   = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_LAST    = 2'd2;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [PHASE_BITS-1:0] phase;
        logic                  first;
    } rfp_pos_t;

endpackage

/* rtl/reading_frame_path_dp_cell.sv */
// Reading-frame path cell for a seven-row Viterbi search. Each input transfer
// carries one cell score (Q16.16) in row order: forward frames 1 to 3, reverse
// frames 1 to 3, then noncoding; tuser bit 0 restarts at row 0 of column 0.
// Each output transfer gives the saturated best path score, the row of the
// chosen previous-column cell, the cell's row, and tlast on the noncoding row.
// The block has an input register and a result register with the candidate add,
// saturate and compare stage between them, and takes one transfer per clock
// while m_tready does not hold the result register. leave_gene_penalty is
// written through the cfg channel while the block is idle and is reset to zero;
// that idle condition binds the user, and the block itself does not enforce it.
module reading_frame_path_dp_cell #(
    parameter int SCORE_BITS = rfp_pkg::SCORE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] cell_score
    input  logic [0:0]  s_tuser,   // [0] sequence_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] path_score, [34:32] best_predecessor,
                                   // [37:35] cell_row, [39:38] zero
    output logic        m_tlast,   // column_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // leave_gene_penalty
);

    localparam int OUT_BITS = (SCORE_BITS > rfp_pkg::DATA_BITS) ?
                              SCORE_BITS : rfp_pkg::DATA_BITS;
    localparam int CUR_ROWS = rfp_pkg::FRAME_ROWS - 1;

    logic                                 in_valid_reg;
    logic signed [rfp_pkg::DATA_BITS-1:0] in_score_reg;
    logic                                 in_start_reg;
    logic                                 out_valid_reg;
    logic [rfp_pkg::DATA_BITS-1:0]        out_score_reg;
    logic [rfp_pkg::ROW_BITS-1:0]         out_pred_reg;
    logic [rfp_pkg::ROW_BITS-1:0]         out_row_reg;
    logic                                 out_last_reg;
    logic signed [rfp_pkg::DATA_BITS-1:0] penalty_reg;
    logic [rfp_pkg::ROW_BITS-1:0]         row_reg;
    logic [rfp_pkg::ROW_BITS-1:0]         row_next;
    logic [rfp_pkg::PHASE_BITS-1:0]       phase_reg;
    logic [rfp_pkg::PHASE_BITS-1:0]       phase_next;
    logic                                 first_reg;
    logic                                 first_next;
    logic signed [SCORE_BITS-1:0]         prev_reg [rfp_pkg::FRAME_ROWS];
    logic signed [SCORE_BITS-1:0]         cur_reg  [CUR_ROWS];

    rfp_pkg::rfp_pos_t                    pos;
    logic                                 advance;
    logic                                 last_row;
    logic signed [SCORE_BITS-1:0]         best;
    logic [rfp_pkg::ROW_BITS-1:0]         pred;
    logic signed [OUT_BITS-1:0]           best_ext;
    logic [rfp_pkg::DATA_BITS-1:0]        out_score_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (in_start_reg) begin
            pos.row   = rfp_pkg::ROW_FIRST;
            pos.phase = rfp_pkg::PHASE_FIRST;
            pos.first = 1'b1;
        end else begin
            pos.row   = row_reg;
            pos.phase = phase_reg;
            pos.first = first_reg;
        end
    end

    assign last_row = (pos.row == rfp_pkg::ROW_NONCODING);

    rfp_select #(
        .SCORE_BITS (SCORE_BITS)
    ) u_select (
        .pos         (pos),
        .cell_score  (in_score_reg),
        .penalty     (penalty_reg),
        .prev_scores (prev_reg),
        .best        (best),
        .pred        (pred)
    );

    always_comb
    begin
        if (last_row) begin
            row_next   = rfp_pkg::ROW_FIRST;
            phase_next = (pos.phase == rfp_pkg::PHASE_LAST) ?
                         rfp_pkg::PHASE_FIRST : pos.phase + 2'd1;
            first_next = 1'b0;
        end else begin
            row_next   = pos.row + 3'd1;
            phase_next = pos.phase;
            first_next = pos.first;
        end
    end

    assign best_ext = OUT_BITS'(best);

    always_comb
    begin
        if ((&best_ext[OUT_BITS-1:rfp_pkg::DATA_BITS-1]) ||
            !(|best_ext[OUT_BITS-1:rfp_pkg::DATA_BITS-1])) begin
            out_score_next = best_ext[rfp_pkg::DATA_BITS-1:0];
        end else if (best_ext[OUT_BITS-1]) begin
            out_score_next = {1'b1, {(rfp_pkg::DATA_BITS-1){1'b0}}};
        end else begin
            out_score_next = {1'b0, {(rfp_pkg::DATA_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            penalty_reg   <= '0;
            row_reg       <= rfp_pkg::ROW_FIRST;
            phase_reg     <= rfp_pkg::PHASE_FIRST;
            first_reg     <= 1'b1;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                row_reg       <= row_next;
                phase_reg     <= phase_next;
                first_reg     <= first_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                penalty_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_score_reg <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance) begin
            out_score_reg <= out_score_next;
            out_pred_reg  <= pred;
            out_row_reg   <= pos.row;
            out_last_reg  <= last_row;
            if (last_row) begin
                for (int i = 0; i < CUR_ROWS; i++) begin
                    prev_reg[i] <= cur_reg[i];
                end
                prev_reg[rfp_pkg::ROW_NONCODING] <= best;
            end else begin
                cur_reg[pos.row] <= best;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_row_reg, out_pred_reg, out_score_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/rfp_select.sv */
module rfp_select #(
    parameter int SCORE_BITS = rfp_pkg::SCORE_BITS_DEFAULT
) (
    input  rfp_pkg::rfp_pos_t                      pos,
    input  logic signed [rfp_pkg::DATA_BITS-1:0]   cell_score,
    input  logic signed [rfp_pkg::DATA_BITS-1:0]   penalty,
    input  logic signed [SCORE_BITS-1:0]           prev_scores [rfp_pkg::FRAME_ROWS],
    output logic signed [SCORE_BITS-1:0]           best,
    output logic [rfp_pkg::ROW_BITS-1:0]           pred
);

    // Score plus twice the penalty needs 34 bits; one more bit holds the sum.
    localparam int SUM_BITS = ((SCORE_BITS > rfp_pkg::DATA_BITS + 2) ?
                               SCORE_BITS : rfp_pkg::DATA_BITS + 2) + 1;

    function automatic logic signed [SCORE_BITS-1:0] sat_score(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-SCORE_BITS:0] top;
        logic signed [SCORE_BITS-1:0] r;
        top = v[SUM_BITS-1:SCORE_BITS-1];
        if ((&top) || !(|top)) begin
            r = v[SCORE_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            r = {1'b1, {(SCORE_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(SCORE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [SUM_BITS-1:0]     t_own;
    logic signed [SUM_BITS-1:0]     t_one;
    logic signed [SUM_BITS-1:0]     t_two;
    logic [rfp_pkg::ROW_BITS-1:0]   mirror_row;
    logic [rfp_pkg::PHASE_BITS-1:0] row_phase;
    logic [rfp_pkg::ROW_BITS-1:0]   cand_row [3];
    logic signed [SUM_BITS-1:0]     cand_t   [3];
    logic signed [SCORE_BITS-1:0]   cand     [3];
    logic                           multi;

    assign t_own = SUM_BITS'(cell_score);
    assign t_one = t_own + SUM_BITS'(penalty);
    assign t_two = t_one + SUM_BITS'(penalty);

    always_comb
    begin
        if (pos.row < rfp_pkg::ROW_REV_BASE) begin
            mirror_row = pos.row + rfp_pkg::ROW_REV_BASE;
            row_phase  = pos.row[rfp_pkg::PHASE_BITS-1:0];
        end else begin
            mirror_row = pos.row - rfp_pkg::ROW_REV_BASE;
            row_phase  = mirror_row[rfp_pkg::PHASE_BITS-1:0];
        end
    end

    // The noncoding row may come from both frames of the current phase and
    // from itself; a coding row of the current phase may also leave noncoding
    // or switch strands; every other coding row only continues itself.
    always_comb
    begin
        cand_row[0] = pos.row;
        cand_row[1] = rfp_pkg::ROW_NONCODING;
        cand_row[2] = mirror_row;
        cand_t[0]   = t_own;
        cand_t[1]   = t_one;
        cand_t[2]   = t_two;
        multi       = 1'b0;
        if (pos.row == rfp_pkg::ROW_NONCODING) begin
            cand_row[0] = {1'b0, pos.phase};
            cand_row[2] = {1'b0, pos.phase} + rfp_pkg::ROW_REV_BASE;
            cand_t[1]   = t_own;
            cand_t[2]   = t_own;
            multi       = 1'b1;
        end else if (row_phase == pos.phase) begin
            multi = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            cand[i] = sat_score(SUM_BITS'(prev_scores[cand_row[i]]) + cand_t[i]);
        end
    end

    always_comb
    begin
        if (pos.first) begin
            best = sat_score(t_own);
            pred = pos.row;
        end else begin
            best = cand[0];
            pred = cand_row[0];
            if (multi && (cand[1] > best)) begin
                best = cand[1];
                pred = cand_row[1];
            end
            if (multi && (cand[2] > cand[0]) && (cand[2] > cand[1])) begin
                best = cand[2];
                pred = cand_row[2];
            end
        end
    end

endmodule

/* rtl/rfp_checker.sv */
module rfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // A result that is not taken stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transfer changed while stalled");

    // The column closes exactly on the noncoding row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[37:35] == rfp_pkg::ROW_NONCODING)))
    else $error("tlast does not match the noncoding row");

    // Rows and predecessors always name one of the seven frame rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[37:35] <= rfp_pkg::ROW_NONCODING) &&
                     (m_tdata[34:32] <= rfp_pkg::ROW_NONCODING))
    else $error("row or predecessor out of range");

    // Rows rise by one or restart at row 0; a new column starts at row 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid || (m_tdata[37:35] == rfp_pkg::ROW_FIRST) ||
            (m_tdata[37:35] == $past(m_tdata[37:35]) + 3'd1))
    else $error("row sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=>
            !m_tvalid || (m_tdata[37:35] == rfp_pkg::ROW_FIRST))
    else $error("column did not restart at row 0");

endmodule

bind reading_frame_path_dp_cell rfp_checker u_rfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/testbench.sv */
module testbench;

    typedef struct packed {
        logic [31:0] score;
        logic        start;
    } cell_t;

    typedef struct packed {
        logic [31:0]                  path_score;
        logic [rfp_pkg::ROW_BITS-1:0] pred;
        logic [rfp_pkg::ROW_BITS-1:0] row;
        logic                         col_end;
    } path_t;

    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam longint SCORE_MIN = -SCORE_MAX - 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    cell_t pending_cells[$];
    path_t expected_paths[$];

    longint      prev_col[rfp_pkg::FRAME_ROWS];
    longint      cur_col[rfp_pkg::FRAME_ROWS];
    int          trk_row = 0;
    int          trk_phase = 0;
    bit          trk_first = 1'b1;
    longint      penalty = 0;

    bit          cell_accepted = 1'b0;
    bit          result_accepted = 1'b0;
    int          send_gap = 0;
    int          sink_wait = 0;
    int          source_idle_max = 8;
    int          sink_idle_max = 8;
    int          failures = 0;

    reading_frame_path_dp_cell uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > SCORE_MAX)
            return SCORE_MAX;
        if (v < SCORE_MIN)
            return SCORE_MIN;
        return v;
    endfunction

    function automatic int frame_of(int r);
        if (r < int'(rfp_pkg::ROW_REV_BASE))
            return r + 1;
        if (r < int'(rfp_pkg::ROW_NONCODING))
            return -(r - 2);
        return 0;
    endfunction

    function automatic int row_of(int f);
        if (f > 0)
            return f - 1;
        if (f < 0)
            return 2 - f;
        return int'(rfp_pkg::ROW_NONCODING);
    endfunction

    // Best path into the current cell; advances the row and column tracking.
    function automatic path_t score_cell(logic [31:0] score, logic start);
        path_t  res;
        int     r;
        int     f;
        int     j;
        int     n;
        int     k;
        int     pf;
        int     pr;
        int     cands[3];
        longint best;
        longint cand;
        longint cost;
        if (start)
        begin
            trk_row = 0;
            trk_phase = 0;
            trk_first = 1'b1;
        end
        r = trk_row;
        best = 0;
        res.pred = r[rfp_pkg::ROW_BITS-1:0];
        if (!trk_first)
        begin
            f = frame_of(r);
            j = trk_phase + 1;
            if (f == 0)
            begin
                cands = '{j, 0, -j};
                n = 3;
            end
            else if (f == j || f == -j)
            begin
                cands = '{f, 0, -f};
                n = 3;
            end
            else
            begin
                cands = '{f, 0, 0};
                n = 1;
            end
            for (k = 0; k < n; k++)
            begin
                pf = cands[k];
                if ((f < 0 && pf > 0) || (f > 0 && pf < 0))
                    cost = 2 * penalty;
                else if (f != 0 && pf != f)
                    cost = penalty;
                else
                    cost = 0;
                cand = clamp32(prev_col[row_of(pf)] + longint'($signed(score)) + cost);
                if (k == 0 || cand > best)
                begin
                    best = cand;
                    pr = row_of(pf);
                    res.pred = pr[rfp_pkg::ROW_BITS-1:0];
                end
            end
        end
        else
            best = longint'($signed(score));
        cur_col[r] = best;
        res.path_score = best[31:0];
        res.row = r[rfp_pkg::ROW_BITS-1:0];
        res.col_end = (r == int'(rfp_pkg::ROW_NONCODING));
        if (r == int'(rfp_pkg::ROW_NONCODING))
        begin
            prev_col = cur_col;
            trk_row = 0;
            trk_phase = (trk_phase + 1) % 3;
            trk_first = 1'b0;
        end
        else
            trk_row = r + 1;
        return res;
    endfunction

    always @(negedge clk)
    begin
        cell_t nxt;
        if (rst_n && (!s_tvalid || cell_accepted))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_cells.size() > 0)
            begin
                nxt = pending_cells.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.score;
                s_tuser <= nxt.start;
                send_gap = $urandom_range(0, source_idle_max);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (result_accepted)
            sink_wait = $urandom_range(0, sink_idle_max);
        if (sink_wait > 0)
        begin
            sink_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        path_t want;
        cell_accepted = s_tvalid && s_tready;
        result_accepted = m_tvalid && m_tready;
        if (rst_n)
        begin
            if (cell_accepted)
                expected_paths.push_back(score_cell(s_tdata, s_tuser[0]));
            if (result_accepted)
            begin
                if (expected_paths.size() == 0)
                begin
                    $error("result transfer with no expected path, tdata %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_paths.pop_front();
                    if (m_tdata[31:0] !== want.path_score)
                    begin
                        $error("path_score: expected %0d, actual %0d",
                               $signed(want.path_score), $signed(m_tdata[31:0]));
                        failures++;
                    end
                    if (m_tdata[34:32] !== want.pred)
                    begin
                        $error("best_predecessor: expected %0d, actual %0d",
                               want.pred, m_tdata[34:32]);
                        failures++;
                    end
                    if (m_tdata[37:35] !== want.row)
                    begin
                        $error("cell_row: expected %0d, actual %0d", want.row, m_tdata[37:35]);
                        failures++;
                    end
                    if (m_tlast !== want.col_end)
                    begin
                        $error("column_end: expected %0d, actual %0d", want.col_end, m_tlast);
                        failures++;
                    end
                end
            end
        end
    end

    task automatic push_cell(input logic [31:0] score, input logic start);
        cell_t item;
        item.score = score;
        item.start = start;
        pending_cells.push_back(item);
    endtask

    function automatic logic [31:0] rand_score();
        int v;
        v = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return (v - 8) * 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_sequences(input int target);
        int   added;
        int   cols;
        int   c;
        int   r;
        logic start;
        added = 0;
        while (added < target)
        begin
            cols = $urandom_range(1, 5);
            for (c = 0; c < cols; c++)
            begin
                for (r = 0; r < rfp_pkg::FRAME_ROWS; r++)
                begin
                    start = (c == 0 && r == 0) && ($urandom_range(0, 7) != 0);
                    if ($urandom_range(0, 39) == 0)
                        start = 1'b1;
                    push_cell(rand_score(), start);
                    added++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cells.size() != 0 || s_tvalid || expected_paths.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_penalty(input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        penalty = longint'($signed(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] penalty_set[6];
        int          p;
        int          r;
        penalty_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                        32'hFFFE_0000, $urandom, 32'h0000_0000};
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // The first column after reset starts without a sequence mark.
        push_cell(32'h7FFF_FFFF, 1'b0);
        push_cell(32'h8000_0000, 1'b0);
        push_cell(32'h0000_0000, 1'b0);
        push_cell(32'hFFFF_FFFF, 1'b0);
        push_cell(32'h0000_0001, 1'b0);
        push_cell(32'h7FFF_FFFF, 1'b0);
        push_cell(32'h8000_0000, 1'b0);
        push_cell(32'h7FFF_FFFF, 1'b0);
        push_cell(32'h8000_0000, 1'b0);
        push_cell(32'h0001_0000, 1'b0);
        push_cell(32'h7FFF_FFFF, 1'b0);
        // The sender holds off in the middle of a column until all results are back.
        wait_idle();
        // Restart mid-column, then equal scores so that every choice is a tie.
        for (r = 0; r < rfp_pkg::FRAME_ROWS; r++)
            push_cell(32'h0002_0000, r == 0);
        for (r = 0; r < rfp_pkg::FRAME_ROWS; r++)
            push_cell(32'h0000_0000, 1'b0);

        for (p = 0; p < 6; p++)
        begin
            wait_idle();
            write_penalty(penalty_set[p]);
            source_idle_max = (p % 3 == 0) ? 0 : 8;
            sink_idle_max = (p % 3 == 1) ? 0 : 8;
            if (p == 4)
            begin
                source_idle_max = 0;
                sink_idle_max = 0;
            end
            queue_sequences(110);
        end

        wait_idle();
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rfp_pkg.sv
rtl/rfp_select.sv
rtl/reading_frame_path_dp_cell.sv
rtl/rfp_checker.sv
tb/testbench.sv
